// ----- rtl/core/rthc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// RGB to HSV converter package
// Payload types, fixed widths and hue angle constants shared by the converter.
// ----------------------------------------------------------------------------
package rthc_pkg;

  localparam int CHANNEL_BITS  = 8;
  localparam int CHANNEL_MAX   = (1 << CHANNEL_BITS) - 1;
  localparam int HUE_BITS      = 15;
  localparam int HUE_FRAC_BITS = 6;

  // Hue numerator stays below 360 degrees times the channel span.
  localparam int HUE_NUM_BITS  = HUE_BITS + CHANNEL_BITS;
  localparam int SAT_NUM_BITS  = 2 * CHANNEL_BITS;

  localparam int DEG60  = 60 << HUE_FRAC_BITS;
  localparam int DEG120 = 120 << HUE_FRAC_BITS;
  localparam int DEG240 = 240 << HUE_FRAC_BITS;
  localparam int DEG360 = 360 << HUE_FRAC_BITS;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [HUE_BITS-1:0]     hue;
    logic [CHANNEL_BITS-1:0] saturation;
    logic [CHANNEL_BITS-1:0] brightness;
  } hsv_t;

  // Offset added to the hue, by sector of the largest channel.
  typedef enum logic [1:0] {
    HUE_BASE_0,
    HUE_BASE_120,
    HUE_BASE_240,
    HUE_BASE_360
  } hue_base_t;

endpackage
`default_nettype wire

// ----- rtl/core/rthc_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// RGB to HSV front end
// Two register stages: max/min and hue sector, then the divider numerators
// and denominators for hue and saturation.
// ----------------------------------------------------------------------------
module rthc_front (
  input  wire logic                                 clk,
  input  wire logic [1:0]                           en,
  input  wire rthc_pkg::pixel_t                     pixel,
  output logic      [rthc_pkg::HUE_NUM_BITS-1:0]    hue_num,
  output logic      [rthc_pkg::CHANNEL_BITS-1:0]    hue_den,
  output logic      [rthc_pkg::SAT_NUM_BITS-1:0]    sat_num,
  output logic      [rthc_pkg::CHANNEL_BITS-1:0]    sat_den,
  output logic      [rthc_pkg::CHANNEL_BITS-1:0]    brightness
);

  localparam int CW  = rthc_pkg::CHANNEL_BITS;
  localparam int HNW = rthc_pkg::HUE_NUM_BITS;
  localparam int SNW = rthc_pkg::SAT_NUM_BITS;

  localparam logic signed [HNW:0] DEG60_S = (HNW+1)'(rthc_pkg::DEG60);

  // stage 1
  logic [CW-1:0]               mx_c;
  logic [CW-1:0]               mn_c;
  logic signed [CW:0]          diff_c;
  rthc_pkg::hue_base_t         base_c;
  logic [CW-1:0]               mx;
  logic [CW-1:0]               span;
  logic signed [CW:0]          diff;
  rthc_pkg::hue_base_t         base;

  // stage 2
  logic [HNW-1:0]              base_term;
  logic signed [HNW:0]         diff_term;
  logic signed [HNW:0]         hue_sum;

  always_comb begin
    mx_c = pixel.red;
    mn_c = pixel.red;
    if (pixel.green > mx_c) mx_c = pixel.green;
    if (pixel.blue > mx_c) mx_c = pixel.blue;
    if (pixel.green < mn_c) mn_c = pixel.green;
    if (pixel.blue < mn_c) mn_c = pixel.blue;

    // red wins ties, then green
    if (mx_c == pixel.red) begin
      diff_c = $signed({1'b0, pixel.green}) - $signed({1'b0, pixel.blue});
      base_c = (pixel.green < pixel.blue) ? rthc_pkg::HUE_BASE_360 : rthc_pkg::HUE_BASE_0;
    end else if (mx_c == pixel.green) begin
      diff_c = $signed({1'b0, pixel.blue}) - $signed({1'b0, pixel.red});
      base_c = rthc_pkg::HUE_BASE_120;
    end else begin
      diff_c = $signed({1'b0, pixel.red}) - $signed({1'b0, pixel.green});
      base_c = rthc_pkg::HUE_BASE_240;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      mx   <= mx_c;
      span <= mx_c - mn_c;
      diff <= diff_c;
      base <= base_c;
    end
  end

  always_comb begin
    case (base)
      rthc_pkg::HUE_BASE_0:   base_term = '0;
      rthc_pkg::HUE_BASE_120: base_term = HNW'(span) * HNW'(rthc_pkg::DEG120);
      rthc_pkg::HUE_BASE_240: base_term = HNW'(span) * HNW'(rthc_pkg::DEG240);
      rthc_pkg::HUE_BASE_360: base_term = HNW'(span) * HNW'(rthc_pkg::DEG360);
      default:                base_term = '0;
    endcase
    diff_term = (HNW+1)'(diff) * DEG60_S;
    hue_sum   = $signed({1'b0, base_term}) + diff_term;
  end

  // A grey or black pixel gives a zero numerator: divide by one to get zero.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      hue_num    <= hue_sum[HNW-1:0];
      hue_den    <= (span == '0) ? CW'(1) : span;
      sat_num    <= SNW'(span) * SNW'(rthc_pkg::CHANNEL_MAX);
      sat_den    <= (mx == '0) ? CW'(1) : mx;
      brightness <= mx;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/rthc_divider.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// RGB to HSV pipelined divider
// Restoring division, a few quotient bits per register stage. The quotient
// must fit in QUO_W bits, so the numerator's top bits start as remainder.
// ----------------------------------------------------------------------------
module rthc_divider #(
  parameter int NUM_W  = 23,
  parameter int DEN_W  = 8,
  parameter int QUO_W  = 15,
  parameter int STAGES = 4
) (
  input  wire logic              clk,
  input  wire logic [STAGES-1:0] en,
  input  wire logic [NUM_W-1:0]  num,
  input  wire logic [DEN_W-1:0]  den,
  output logic      [QUO_W-1:0]  quo
);

  localparam int STEPS = (QUO_W + STAGES - 1) / STAGES;

  logic [DEN_W-1:0] rem_q [STAGES-1];
  logic [QUO_W-1:0] low_q [STAGES-1];
  logic [QUO_W-1:0] part_q[STAGES-1];
  logic [DEN_W-1:0] den_q [STAGES-1];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [QUO_W-1:0] low_in;
    logic [QUO_W-1:0] part_in;
    logic [DEN_W-1:0] den_in;
    logic [DEN_W-1:0] rem_c;
    logic [QUO_W-1:0] low_c;
    logic [QUO_W-1:0] part_c;

    if (k == 0) begin : g_load
      assign rem_in  = DEN_W'(num[NUM_W-1:QUO_W]);
      assign low_in  = num[QUO_W-1:0];
      assign part_in = '0;
      assign den_in  = den;
    end else begin : g_chain
      assign rem_in  = rem_q[k-1];
      assign low_in  = low_q[k-1];
      assign part_in = part_q[k-1];
      assign den_in  = den_q[k-1];
    end

    always_comb begin
      logic [DEN_W:0] trial;
      rem_c  = rem_in;
      low_c  = low_in;
      part_c = part_in;
      trial  = '0;
      for (int j = 0; j < STEPS; j++) begin
        if (k * STEPS + j < QUO_W) begin
          trial = {rem_c, low_c[QUO_W-1]};
          low_c = low_c << 1;
          if (trial >= {1'b0, den_in}) begin
            rem_c  = DEN_W'(trial - {1'b0, den_in});
            part_c = {part_c[QUO_W-2:0], 1'b1};
          end else begin
            rem_c  = trial[DEN_W-1:0];
            part_c = {part_c[QUO_W-2:0], 1'b0};
          end
        end
      end
    end

    if (k < STAGES - 1) begin : g_mid
      always_ff @(posedge clk) begin
        if (en[k]) begin
          rem_q[k]  <= rem_c;
          low_q[k]  <= low_c;
          part_q[k] <= part_c;
          den_q[k]  <= den_in;
        end
      end
    end else begin : g_last
      always_ff @(posedge clk) begin
        if (en[k]) begin
          quo <= part_c;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/rgb_to_hsv_pixel_converter.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// RGB to HSV pixel converter
// Converts one RGB pixel per clock, while hsv_ready is high, into hue
// (degrees x 64), saturation and value (brightness).
//
// Usage:
//   pixel / pixel_valid / pixel_ready : input items, red, green and blue.
//   hsv / hsv_valid / hsv_ready       : result items, one per pixel, in order.
//   Throughput is one item per cycle while hsv_ready is high. The item passes
//   DIV_STAGES + 2 register stages: two front stages (max/min and sector,
//   then numerators), then DIV_STAGES stages of the hue and saturation
//   dividers, each retiring a few quotient bits per stage.
//   Every stage holds its own valid bit; a stage takes a new item when it is
//   empty or the stage after it moves, so bubbles close up while hsv_ready is
//   low and pixel_ready drops only once every stage holds an item.
//   The final divider stage is the output register: a stalled result holds.
//   Synchronous reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel_converter #(
  parameter int DIV_STAGES = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             pixel_valid,
  output logic                  pixel_ready,
  input  wire rthc_pkg::pixel_t pixel,
  output logic                  hsv_valid,
  input  wire logic             hsv_ready,
  output rthc_pkg::hsv_t        hsv
);

  localparam int CW    = rthc_pkg::CHANNEL_BITS;
  localparam int PIPE  = DIV_STAGES + 2;

  logic [PIPE-1:0] valid;
  logic [PIPE-1:0] valid_next;
  logic [PIPE-1:0] en;

  logic [rthc_pkg::HUE_NUM_BITS-1:0] hue_num;
  logic [CW-1:0]                     hue_den;
  logic [rthc_pkg::SAT_NUM_BITS-1:0] sat_num;
  logic [CW-1:0]                     sat_den;
  logic [CW-1:0]                     front_bright;
  logic [rthc_pkg::HUE_BITS-1:0]     hue_quo;
  logic [CW-1:0]                     sat_quo;
  logic [CW-1:0]                     bright [DIV_STAGES];

  // advance a stage when it is empty or its successor advances
  always_comb begin
    en[PIPE-1] = !valid[PIPE-1] || hsv_ready;
    for (int i = PIPE - 2; i >= 0; i--) begin
      en[i] = !valid[i] || en[i+1];
    end
    valid_next = {valid[PIPE-2:0], pixel_valid};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      for (int i = 0; i < PIPE; i++) begin
        if (en[i]) valid[i] <= valid_next[i];
      end
    end
  end

  assign pixel_ready = en[0];
  assign hsv_valid   = valid[PIPE-1];

  rthc_front u_front (
    .clk        (clk),
    .en         (en[1:0]),
    .pixel      (pixel),
    .hue_num    (hue_num),
    .hue_den    (hue_den),
    .sat_num    (sat_num),
    .sat_den    (sat_den),
    .brightness (front_bright)
  );

  rthc_divider #(
    .NUM_W  (rthc_pkg::HUE_NUM_BITS),
    .DEN_W  (CW),
    .QUO_W  (rthc_pkg::HUE_BITS),
    .STAGES (DIV_STAGES)
  ) u_hue_div (
    .clk (clk),
    .en  (en[PIPE-1:2]),
    .num (hue_num),
    .den (hue_den),
    .quo (hue_quo)
  );

  rthc_divider #(
    .NUM_W  (rthc_pkg::SAT_NUM_BITS),
    .DEN_W  (CW),
    .QUO_W  (CW),
    .STAGES (DIV_STAGES)
  ) u_sat_div (
    .clk (clk),
    .en  (en[PIPE-1:2]),
    .num (sat_num),
    .den (sat_den),
    .quo (sat_quo)
  );

  // carry brightness alongside the dividers
  always_ff @(posedge clk) begin
    if (en[2]) bright[0] <= front_bright;
    for (int k = 1; k < DIV_STAGES; k++) begin
      if (en[k+2]) bright[k] <= bright[k-1];
    end
  end

  assign hsv.hue        = hue_quo;
  assign hsv.saturation = sat_quo;
  assign hsv.brightness = bright[DIV_STAGES-1];

endmodule
`default_nettype wire
